// ----- hw/rtl/retry_outbox_slot_manager_defines.svh -----
// ----------------------------------------------------------------------------
// retry outbox slot manager assertion macros
// concurrent checks used by the rtl, same-cycle and next-cycle forms
// ----------------------------------------------------------------------------
`ifndef RETRY_OUTBOX_SLOT_MANAGER_DEFINES_SVH
`define RETRY_OUTBOX_SLOT_MANAGER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define ROSM_ASSERT_SAME(LBL, CLK, RST, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error(MSG);

// condition must hold in the cycle after the trigger
`define ROSM_ASSERT_NEXT(LBL, CLK, RST, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

// ----- hw/rtl/rosm_pkg.sv -----
// ----------------------------------------------------------------------------
// rosm_pkg
// shared widths, codes, slot record and scan result types
// ----------------------------------------------------------------------------
package rosm_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int SLOT_COUNT_MAX = 64;
  localparam int SLOT_IDX_MAX_W = $clog2(SLOT_COUNT_MAX);

  localparam int SEQ_W    = 32;
  localparam int KIND_W   = 2;
  localparam int BYTES_W  = 32;
  localparam int TRIES_W  = 8;
  localparam int TAG_W    = 64;
  localparam int UPTIME_W = 32;
  localparam int HTTP_W   = 10;
  localparam int STATUS_W = 3;
  localparam int CAUSE_W  = 2;
  localparam int PEND_W   = 7;

  // request actions
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_REPORT  = 1'b1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_VOICE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_JOURNAL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ACK_DROPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

  // release causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_FORWARD   = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_EXHAUSTED = 2'd2;

  localparam logic [TRIES_W-1:0] TRIES_RESET = 8'd5;
  localparam logic [TRIES_W-1:0] TRIES_SAT   = 8'd255;
  localparam logic [HTTP_W-1:0]  HTTP_OK_LO  = 10'd200;
  localparam logic [HTTP_W-1:0]  HTTP_OK_HI  = 10'd300;

  // per-slot record kept in the data memory
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTES_W-1:0]  bytes;
    logic [TRIES_W-1:0]  tries;
    logic                link;
    logic [TAG_W-1:0]    tag;
    logic [UPTIME_W-1:0] uptime;
  } slot_data_t;

  // reference to an occupied slot: its sequence and index
  typedef struct packed {
    logic                      vld;
    logic [SEQ_W-1:0]          seq;
    logic [SLOT_IDX_MAX_W-1:0] idx;
  } slot_ref_t;

  // outcome of one pass over the sequence memory
  typedef struct packed {
    logic                      done;
    slot_ref_t                 best;
    slot_ref_t                 second;
    logic                      free_vld;
    logic [SLOT_IDX_MAX_W-1:0] free_idx;
  } scan_res_t;

  // older of two slot references, lower index wins a tie
  function automatic slot_ref_t ref_min(slot_ref_t a, slot_ref_t b);
    slot_ref_t r;
    r = a;
    if (!a.vld) begin
      r = b;
    end else if (b.vld && ((b.seq < a.seq) || ((b.seq == a.seq) && (b.idx < a.idx)))) begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rosm_ram.sv -----
// ----------------------------------------------------------------------------
// rosm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rosm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rosm_scan.sv -----
// ----------------------------------------------------------------------------
// rosm_scan
// walks the sequence memory one slot a cycle and finds the oldest slot,
// the next oldest slot and the lowest free slot
// ----------------------------------------------------------------------------
module rosm_scan import rosm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SLOT_COUNT-1:0] slot_vld,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [SEQ_W-1:0]      rd_seq,
  output scan_res_t             res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic                      running;
  logic [IDX_W-1:0]          cnt;
  logic                      proc_vld;
  logic                      proc_last;
  logic [IDX_W-1:0]          proc_idx;
  logic                      done;
  slot_ref_t                 best;
  slot_ref_t                 second;
  logic                      free_vld;
  logic [SLOT_IDX_MAX_W-1:0] free_idx;
  slot_ref_t                 cand;

  // address issue and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      proc_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      proc_vld <= running;
      done     <= proc_vld && proc_last;
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == LAST_IDX)) begin
        running <= 1'b0;
      end
    end
  end

  // address counter and the index that lines up with returning data
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
    end else if (running) begin
      cnt <= cnt + IDX_W'(1);
    end
    proc_idx  <= cnt;
    proc_last <= (cnt == LAST_IDX);
  end

  // candidate from the word that just came back
  always_comb begin
    cand.vld = 1'b1;
    cand.seq = rd_seq;
    cand.idx = SLOT_IDX_MAX_W'(proc_idx);
  end

  // running minimum and second minimum, first free slot
  always_ff @(posedge clk) begin
    if (start) begin
      best.vld   <= 1'b0;
      second.vld <= 1'b0;
      free_vld   <= 1'b0;
    end else if (proc_vld) begin
      if (slot_vld[proc_idx]) begin
        if (!best.vld || (rd_seq < best.seq)) begin
          second <= best;
          best   <= cand;
        end else if (!second.vld || (rd_seq < second.seq)) begin
          second <= cand;
        end
      end else if (!free_vld) begin
        free_vld <= 1'b1;
        free_idx <= cand.idx;
      end
    end
  end

  assign rd_en   = running;
  assign rd_addr = cnt;

  always_comb begin
    res.done     = done;
    res.best     = best;
    res.second   = second;
    res.free_vld = free_vld;
    res.free_idx = free_idx;
  end

endmodule

// ----- hw/rtl/retry_outbox_slot_manager.sv -----
// A new request is taken only in the idle state, once the previous result has moved into
// the output register. The request rate is set by the sequence memory scan, one slot read
// per cycle on its single port.
// A finished result waits in the output register while the next request is taken.
// Reset: occupancy bits clear at once, no clearing pass; sequence counter goes to 1,
// max_tries goes to 5; slot memory contents are left as they are.
// ----------------------------------------------------------------------------
// retry_outbox_slot_manager
// fixed table of outbox slots kept in two memories, forwarded oldest first,
// with eviction of the oldest on full (an ack is dropped instead), retry counting and delivery release
// ----------------------------------------------------------------------------
`include "retry_outbox_slot_manager_defines.svh"

module retry_outbox_slot_manager import rosm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [KIND_W-1:0]   kind,
  input  logic [BYTES_W-1:0]  byte_count,
  input  logic [BYTES_W-1:0]  journal_size,
  input  logic                link_up,
  input  logic [TAG_W-1:0]    time_tag,
  input  logic [UPTIME_W-1:0] uptime_s,
  input  logic                delivered,
  input  logic [HTTP_W-1:0]   http_status,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SEQ_W-1:0]    seq,
  output logic                evicted,
  output logic [CAUSE_W-1:0]  release_cause,
  output logic [PEND_W-1:0]   pending_count,
  output logic                head_valid,
  output logic [KIND_W-1:0]   head_kind,
  output logic [SEQ_W-1:0]    head_seq,
  output logic [BYTES_W-1:0]  head_bytes,
  output logic [TAG_W-1:0]    head_tag,
  output logic [UPTIME_W-1:0] head_uptime,
  output logic                head_link_up,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TRIES_W-1:0]  cfg_data
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int DATA_W = $bits(slot_data_t);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_PLAN = 6'b000100,
    S_RPT  = 6'b001000,
    S_HEAD = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [TRIES_W-1:0]    max_tries;
  logic [SEQ_W-1:0]      next_seq;
  logic [SEQ_W-1:0]      next_seq_next;
  logic [SLOT_COUNT-1:0] slot_vld;
  logic [CNT_W-1:0]      cnt;

  // latched request
  logic                  req_action;
  logic [KIND_W-1:0]     req_kind;
  logic [BYTES_W-1:0]    req_bytes;
  logic [BYTES_W-1:0]    req_journal;
  logic                  req_link;
  logic [TAG_W-1:0]      req_tag;
  logic [UPTIME_W-1:0]   req_uptime;
  logic                  req_delivered;
  logic [HTTP_W-1:0]     req_http;

  // result under construction
  logic [STATUS_W-1:0]   res_status;
  logic [SEQ_W-1:0]      res_seq;
  logic                  res_evicted;
  logic [CAUSE_W-1:0]    res_cause;
  slot_ref_t             head_ref;

  // memory ports
  logic                  seq_re;
  logic [IDX_W-1:0]      seq_raddr;
  logic [SEQ_W-1:0]      seq_rdata;
  logic                  seq_we;
  logic                  dat_we;
  logic [IDX_W-1:0]      dat_waddr;
  slot_data_t            dat_wdata;
  logic                  dat_re;
  logic [IDX_W-1:0]      dat_raddr;
  slot_data_t            dat_rdata;

  scan_res_t             scan;
  logic                  accept;

  // enqueue plan
  logic                  is_voice;
  logic                  is_mark;
  logic                  is_ack;
  logic                  enq_reject;
  logic                  enq_go;
  logic                  enq_evict;
  logic [STATUS_W-1:0]   enq_status;
  logic [IDX_W-1:0]      enq_idx;
  slot_ref_t             new_ref;
  slot_ref_t             enq_head;
  slot_data_t            enq_data;
  logic [IDX_W-1:0]      best_idx;

  // report plan
  logic                  ok2xx;
  logic [TRIES_W-1:0]    tries_inc;
  logic                  rpt_fwd;
  logic                  rpt_exh;
  slot_data_t            rpt_data;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign best_idx  = scan.best.idx[IDX_W-1:0];

  // sequence counter skips zero on wrap
  assign next_seq_next = (next_seq == '1) ? SEQ_W'(1) : next_seq + SEQ_W'(1);

  // enqueue decision from the request and the scan outcome
  always_comb begin
    is_voice   = (req_kind == KIND_VOICE);
    is_mark    = (req_kind == KIND_MARK);
    is_ack     = (req_kind == KIND_ACK);
    enq_reject = (req_kind == KIND_NONE) ||
                 (is_voice && ((req_bytes == '0) || (req_journal == '0)));
    enq_go     = !enq_reject && (scan.free_vld || !is_ack);
    enq_evict  = enq_go && !scan.free_vld;
    if (is_voice && (req_bytes == '0)) begin
      enq_status = ST_ZERO_LEN;
    end else if (is_voice && (req_journal == '0)) begin
      enq_status = ST_NO_JOURNAL;
    end else if (!enq_reject && !scan.free_vld && is_ack) begin
      enq_status = ST_ACK_DROPPED;
    end else begin
      enq_status = ST_OK;
    end
    enq_idx     = scan.free_vld ? scan.free_idx[IDX_W-1:0] : best_idx;
    new_ref.vld = 1'b1;
    new_ref.seq = next_seq;
    new_ref.idx = SLOT_IDX_MAX_W'(enq_idx);
    if (!enq_go) begin
      enq_head = scan.best;
    end else if (enq_evict) begin
      enq_head = ref_min(scan.second, new_ref);
    end else begin
      enq_head = ref_min(scan.best, new_ref);
    end
    enq_data.kind   = req_kind;
    enq_data.tries  = '0;
    enq_data.tag    = req_tag;
    enq_data.uptime = req_uptime;
    enq_data.link   = is_mark ? req_link : 1'b0;
    if (is_voice) begin
      enq_data.bytes = (req_bytes < req_journal) ? req_bytes : req_journal;
    end else if (is_mark) begin
      enq_data.bytes = '0;
    end else begin
      enq_data.bytes = req_bytes;
    end
  end

  // report decision from the oldest slot's record
  always_comb begin
    ok2xx     = (dat_rdata.kind == KIND_VOICE) &&
                (req_http >= HTTP_OK_LO) && (req_http < HTTP_OK_HI);
    tries_inc = (dat_rdata.tries == TRIES_SAT) ? dat_rdata.tries
                                               : dat_rdata.tries + TRIES_W'(1);
    rpt_fwd   = req_delivered || ok2xx;
    rpt_exh   = !rpt_fwd && (tries_inc >= max_tries);
    rpt_data       = dat_rdata;
    rpt_data.tries = tries_inc;
  end

  // sequencer and memory port control
  always_comb begin
    state_next = state;
    seq_we     = 1'b0;
    dat_we     = 1'b0;
    dat_waddr  = enq_idx;
    dat_wdata  = enq_data;
    dat_re     = 1'b0;
    dat_raddr  = best_idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        if (req_action == ACT_ENQUEUE) begin
          seq_we     = enq_go;
          dat_we     = enq_go;
          state_next = S_HEAD;
        end else if (!scan.best.vld) begin
          state_next = S_HEAD;
        end else begin
          dat_re     = 1'b1;
          state_next = S_RPT;
        end
      end
      S_RPT: begin
        dat_we     = !(rpt_fwd || rpt_exh);
        dat_waddr  = best_idx;
        dat_wdata  = rpt_data;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        dat_re     = head_ref.vld;
        dat_raddr  = head_ref.idx[IDX_W-1:0];
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_tries <= TRIES_RESET;
      next_seq  <= SEQ_W'(1);
      slot_vld  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_tries <= cfg_data;
      end
      if ((state == S_PLAN) && (req_action == ACT_ENQUEUE) && enq_go) begin
        next_seq <= next_seq_next;
        if (scan.free_vld) begin
          slot_vld[enq_idx] <= 1'b1;
          cnt               <= cnt + CNT_W'(1);
        end
      end
      if ((state == S_RPT) && (rpt_fwd || rpt_exh)) begin
        slot_vld[best_idx] <= 1'b0;
        cnt                <= cnt - CNT_W'(1);
      end
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture, result build-up and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action    <= action;
      req_kind      <= kind;
      req_bytes     <= byte_count;
      req_journal   <= journal_size;
      req_link      <= link_up;
      req_tag       <= time_tag;
      req_uptime    <= uptime_s;
      req_delivered <= delivered;
      req_http      <= http_status;
    end
    if (state == S_PLAN) begin
      res_evicted <= 1'b0;
      res_cause   <= CAUSE_NONE;
      if (req_action == ACT_ENQUEUE) begin
        res_status  <= enq_status;
        res_seq     <= enq_go ? next_seq : '0;
        res_evicted <= enq_evict;
        head_ref    <= enq_head;
      end else if (!scan.best.vld) begin
        res_status <= ST_EMPTY;
        res_seq    <= '0;
        head_ref   <= scan.best;
      end else begin
        res_status <= ST_OK;
        res_seq    <= scan.best.seq;
      end
    end
    if (state == S_RPT) begin
      if (rpt_fwd) begin
        res_cause <= CAUSE_FORWARD;
        head_ref  <= scan.second;
      end else if (rpt_exh) begin
        res_cause <= CAUSE_EXHAUSTED;
        head_ref  <= scan.second;
      end else begin
        head_ref  <= scan.best;
      end
    end
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      status        <= res_status;
      seq           <= res_seq;
      evicted       <= res_evicted;
      release_cause <= res_cause;
      pending_count <= PEND_W'(cnt);
      head_valid    <= head_ref.vld;
      head_seq      <= head_ref.vld ? head_ref.seq : '0;
      head_kind     <= head_ref.vld ? dat_rdata.kind : '0;
      head_bytes    <= head_ref.vld ? dat_rdata.bytes : '0;
      head_tag      <= head_ref.vld ? dat_rdata.tag : '0;
      head_uptime   <= head_ref.vld ? dat_rdata.uptime : '0;
      head_link_up  <= head_ref.vld ? dat_rdata.link : 1'b0;
    end
  end

  // slot sequence memory, read only by the scan
  rosm_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (SLOT_COUNT)
  ) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (enq_idx),
    .wdata (next_seq),
    .re    (seq_re),
    .raddr (seq_raddr),
    .rdata (seq_rdata)
  );

  // slot record memory
  rosm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOT_COUNT)
  ) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .re    (dat_re),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  // oldest, next oldest and free slot search
  rosm_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .slot_vld (slot_vld),
    .rd_en    (seq_re),
    .rd_addr  (seq_raddr),
    .rd_seq   (seq_rdata),
    .res      (scan)
  );

  // checks
  `ROSM_ASSERT_SAME(a_cnt_match, clk, rst, 1'b1, (int'(cnt) == $countones(slot_vld)), "occupancy count disagrees with slot bits")
  `ROSM_ASSERT_SAME(a_head_cnt, clk, rst, (state == S_OUT), (head_ref.vld == (cnt != '0)), "head presence disagrees with occupancy")
  `ROSM_ASSERT_SAME(a_done_in_scan, clk, rst, scan.done, (state == S_SCAN), "scan finished outside the scan state")
  `ROSM_ASSERT_SAME(a_free_found, clk, rst, scan.done, (scan.free_vld == !(&slot_vld)), "free slot search missed")
  `ROSM_ASSERT_NEXT(a_accept_scan, clk, rst, accept, (state == S_SCAN), "accepted request did not start a scan")

endmodule
